// ===== hdl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants for the decision tree classify unit.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int MAX_DEPTH    = 8;
  localparam int MAX_FEATURES = 16;
  localparam int MAX_CLASSES  = 8;
  localparam int NODE_COUNT   = (1 << MAX_DEPTH) - 1;
  localparam int PROB_DEPTH   = NODE_COUNT * MAX_CLASSES;

  localparam int NODE_W  = 8;
  localparam int FEAT_W  = 4;
  localparam int CLASS_W = 3;
  localparam int LEVEL_W = 3;
  localparam int VAL_W   = 16;
  localparam int SCORE_W = 24;
  localparam int PADDR_W = 3;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // op codes
  localparam logic [2:0] OP_NODE     = 3'd0;
  localparam logic [2:0] OP_FEATURE  = 3'd1;
  localparam logic [2:0] OP_PROB     = 3'd2;
  localparam logic [2:0] OP_CLASSIFY = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  // register indexes
  localparam logic REG_DEPTH   = 1'b0;
  localparam logic REG_CLASSES = 1'b1;

  typedef struct packed {
    logic                    leaf;
    logic [FEAT_W-1:0]       feat;
    logic signed [VAL_W-1:0] thr;
  } node_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [3:0]         depth;
    logic [CLASS_W-1:0] cls_last;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic walk_start;
    logic walk_step;
    logic issue;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic last_issue;
  } dp_status_t;

endpackage

// ===== hdl/dtc_regs.sv =====
// ----------------------------------------------------------------------------
// dtc_regs
// APB register file: tree depth and class count, with clamped outputs.
// ----------------------------------------------------------------------------
module dtc_regs import dtc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [3:0] depth_in_use;
  logic [3:0] class_count;
  logic       wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_in_use <= 4'd8;
      class_count  <= 4'd3;
    end else if (wr) begin
      case (paddr[2])
        REG_DEPTH:   depth_in_use <= pwdata[3:0];
        REG_CLASSES: class_count  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEPTH:   prdata = {28'd0, depth_in_use};
      REG_CLASSES: prdata = {28'd0, class_count};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (depth_in_use == 4'd0)
      cfg.depth = 4'd1;
    else if (depth_in_use > 4'(MAX_DEPTH))
      cfg.depth = 4'(MAX_DEPTH);
    else
      cfg.depth = depth_in_use;

    if (class_count == 4'd0)
      cfg.cls_last = '0;
    else if (class_count > 4'(MAX_CLASSES))
      cfg.cls_last = CLASS_W'(MAX_CLASSES - 1);
    else
      cfg.cls_last = CLASS_W'(class_count - 4'd1);
  end

endmodule

// ===== hdl/dtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer: tree walk, one probability read per class, final drain.
// ----------------------------------------------------------------------------
module dtc_ctrl import dtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] op,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_PROB  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.accept     = start && (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (start && op == OP_CLASSIFY) begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (status.walk_done)
          state_next = S_PROB;
        else
          cmd.walk_step = 1'b1;
      end
      S_PROB: begin
        cmd.issue = 1'b1;
        if (status.last_issue)
          state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

endmodule

// ===== hdl/dtc_datapath.sv =====
// ----------------------------------------------------------------------------
// dtc_datapath
// Node, feature and probability stores, walk registers, score accumulators
// and the result register.
// ----------------------------------------------------------------------------
module dtc_datapath import dtc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  cfg_t                      cfg,
  input  logic [2:0]                op,
  input  logic [NODE_W-1:0]         node_index,
  input  logic                      is_leaf,
  input  logic [FEAT_W-1:0]         feature_index,
  input  logic signed [VAL_W-1:0]   sample_value,
  input  logic [CLASS_W-1:0]        class_index,
  input  logic [VAL_W-1:0]          prob_value,
  output logic                      valid,
  output logic [CLASS_W-1:0]        class_id,
  output logic [SCORE_W-1:0]        score,
  output logic [NODE_W-1:0]         leaf_reached,
  output logic                      last
);

  node_t                   node_mem [NODE_COUNT];
  logic [VAL_W-1:0]        prob_mem [PROB_DEPTH];
  logic signed [VAL_W-1:0] feature_store [MAX_FEATURES];
  logic [SCORE_W-1:0]      class_scores [MAX_CLASSES];

  node_t                   node_rd;
  logic [VAL_W-1:0]        prob_rd;
  logic [NODE_W-1:0]       node_addr;
  logic [NODE_W-1:0]       pos;
  logic [NODE_W-1:0]       pos_next;
  logic [NODE_W:0]         child;
  logic [LEVEL_W-1:0]      level;
  logic [CLASS_W-1:0]      k;
  logic                    e_valid;
  logic [CLASS_W-1:0]      e_k;
  logic                    e_last;
  logic signed [VAL_W-1:0] feat_val;
  logic                    go_left;
  logic [SCORE_W:0]        sum;
  logic [SCORE_W-1:0]      sum_sat;

  // ---- node store: written by node loads, read once per walk step
  always_ff @(posedge clk) begin
    if (cmd.accept && op == OP_NODE && {1'b0, node_index} < (NODE_W+1)'(NODE_COUNT))
      node_mem[node_index] <= '{leaf: is_leaf, feat: feature_index, thr: sample_value};
    node_rd <= node_mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && op == OP_FEATURE && {1'b0, feature_index} < (FEAT_W+1)'(MAX_FEATURES))
      feature_store[feature_index] <= sample_value;
  end

  // ---- walk
  assign feat_val = feature_store[node_rd.feat];
  assign go_left  = (feat_val <= node_rd.thr);
  assign child    = ({1'b0, pos} << 1) + (go_left ? (NODE_W+1)'(1) : (NODE_W+1)'(2));
  assign pos_next = child[NODE_W-1:0];
  assign node_addr = cmd.walk_start ? '0 : pos_next;

  assign status.walk_done  = node_rd.leaf || ({1'b0, level} + 4'd1 >= cfg.depth);
  assign status.last_issue = (k == cfg.cls_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      level <= '0;
    end else if (cmd.walk_start) begin
      pos   <= '0;
      level <= '0;
    end else if (cmd.walk_step) begin
      pos   <= pos_next;
      level <= level + LEVEL_W'(1);
    end
  end

  // ---- leaf probabilities: one read per class, address {leaf, class}
  always_ff @(posedge clk) begin
    if (cmd.accept && op == OP_PROB && {1'b0, node_index} < (NODE_W+1)'(NODE_COUNT)
        && {1'b0, class_index} < (CLASS_W+1)'(MAX_CLASSES))
      prob_mem[{node_index, class_index}] <= prob_value;
    prob_rd <= prob_mem[{pos, k}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      e_valid <= 1'b0;
    end else begin
      e_valid <= cmd.issue;
      if (cmd.walk_start)
        k <= '0;
      else if (cmd.issue)
        k <= k + CLASS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      e_k    <= k;
      e_last <= status.last_issue;
    end
  end

  // ---- saturating accumulate
  assign sum     = {1'b0, class_scores[e_k]} + (SCORE_W+1)'(prob_rd);
  assign sum_sat = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CLASSES; i++)
        class_scores[i] <= '0;
    end else if (cmd.accept && op == OP_CLEAR) begin
      for (int i = 0; i < MAX_CLASSES; i++)
        class_scores[i] <= '0;
    end else if (e_valid) begin
      class_scores[e_k] <= sum_sat;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst)
      valid <= 1'b0;
    else
      valid <= e_valid;
  end

  always_ff @(posedge clk) begin
    if (e_valid) begin
      class_id     <= e_k;
      score        <= sum_sat;
      leaf_reached <= pos;
      last         <= e_last;
    end
  end

endmodule

// ===== hdl/decision_tree_classify_unit.sv =====
// ----------------------------------------------------------------------------
// decision_tree_classify_unit
// Decision tree inference over a heap-ordered tree with saturating per-class
// score accumulation.
// ----------------------------------------------------------------------------
// Load ops (node, feature, leaf probability, clear) are taken while idle and
// leave busy low. A classify holds busy while it walks the tree, one level
// per step (at most depth_eff levels) through the registered node store
// read, then issues one probability store read per class, pipelined with the
// accumulate, and ends with one drain state before busy drops.
// Results come out one per cycle, marked by valid, one transfer per cycle;
// there is no backpressure, so the receiver must take each result in the
// cycle it is shown. The last result of a classify appears in the first cycle
// with busy low. Stores other than the scores hold no reset contents.
module decision_tree_classify_unit import dtc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              op,
  input  logic [NODE_W-1:0]       node_index,
  input  logic                    is_leaf,
  input  logic [FEAT_W-1:0]       feature_index,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic [CLASS_W-1:0]      class_index,
  input  logic [VAL_W-1:0]        prob_value,
  output logic                    valid,
  output logic [CLASS_W-1:0]      class_id,
  output logic [SCORE_W-1:0]      score,
  output logic [NODE_W-1:0]       leaf_reached,
  output logic                    last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  dtc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dtc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .op            (op),
    .node_index    (node_index),
    .is_leaf       (is_leaf),
    .feature_index (feature_index),
    .sample_value  (sample_value),
    .class_index   (class_index),
    .prob_value    (prob_value),
    .valid         (valid),
    .class_id      (class_id),
    .score         (score),
    .leaf_reached  (leaf_reached),
    .last          (last)
  );

endmodule
